/* hw/rtl/svct_pkg.sv */
// shared types and constants for the smallest values count table
package svct_pkg;

    localparam int ENTRIES_DEFAULT = 10;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 32;
    localparam int INDEX_W         = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [VALUE_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               entry_valid;
        logic [VALUE_W-1:0] entry_value;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic               rec_en;
        logic               dump_en;
        logic               dump_last;
        logic [INDEX_W-1:0] dump_index;
    } cmd_t;

endpackage

/* hw/rtl/svct_ctrl.sv */
// controller: accepts requests and sequences the dump of the table
module svct_ctrl #(
    parameter int ENTRIES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        opcode,
    output logic        busy,
    output svct_pkg::cmd_t cmd
);
    import svct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             accept;

    assign busy   = (state_reg == S_DUMP);
    assign accept = start && !busy;

    always_comb
    begin
        cmd.rec_en     = accept && (opcode == OP_RECORD);
        cmd.dump_en    = (state_reg == S_DUMP);
        cmd.dump_last  = (state_reg == S_DUMP) && (idx_reg == LAST_IDX);
        cmd.dump_index = INDEX_W'(idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (accept && (opcode == OP_DUMP))
                    begin
                        state_reg <= S_DUMP;
                    end
                end
                S_DUMP:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                        idx_reg   <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    idx_reg   <= '0;
                end
            endcase
        end
    end

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_last |=> !busy)
        else $error("dump did not end after last slot");

    a_dump_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_DUMP)) |=> (busy && (idx_reg == '0)))
        else $error("dump request did not start at slot zero");

    a_no_record_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.rec_en)
        else $error("record issued during dump");

endmodule

/* hw/rtl/svct_datapath.sv */
// datapath: sorted slot table with parallel compare, insert and rotate for dump
module svct_datapath #(
    parameter int ENTRIES = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  svct_pkg::cmd_t            cmd,
    input  logic [svct_pkg::VALUE_W-1:0] sample_value,
    output logic                      result_strobe,
    output svct_pkg::out_item_t       result
);
    import svct_pkg::*;

    logic [VALUE_W-1:0] value_reg  [ENTRIES];
    logic [COUNT_W-1:0] count_reg  [ENTRIES];
    logic [VALUE_W-1:0] value_next [ENTRIES];
    logic [COUNT_W-1:0] count_next [ENTRIES];
    logic [VALUE_W-1:0] value_rot  [ENTRIES];
    logic [COUNT_W-1:0] count_rot  [ENTRIES];
    logic [VALUE_W-1:0] value_prev [ENTRIES];
    logic [COUNT_W-1:0] count_prev [ENTRIES];
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] greater;
    logic [ENTRIES-1:0] greater_prev;
    logic               any_match;
    logic               strobe_reg;
    out_item_t          result_reg;
    logic               head_valid;

    // per-slot compare; table is ascending with empty slots at the end
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = (count_reg[i] != '0) && (value_reg[i] == sample_value);
            greater[i] = (count_reg[i] == '0) || (sample_value < value_reg[i]);
        end
    end

    assign any_match = |match;

    // neighbor taps: previous slot for insert shift, next slot for dump rotate
    always_comb
    begin
        greater_prev[0] = 1'b0;
        value_prev[0]   = value_reg[0];
        count_prev[0]   = count_reg[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            greater_prev[i] = greater[i-1];
            value_prev[i]   = value_reg[i-1];
            count_prev[i]   = count_reg[i-1];
        end
        for (int i = 0; i < ENTRIES - 1; i++)
        begin
            value_rot[i] = value_reg[i+1];
            count_rot[i] = count_reg[i+1];
        end
        value_rot[ENTRIES-1] = value_reg[0];
        count_rot[ENTRIES-1] = count_reg[0];
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.dump_en)
            begin
                // a full dump rotates the table once around
                value_next[i] = value_rot[i];
                count_next[i] = count_rot[i];
            end
            else if (cmd.rec_en)
            begin
                if (match[i])
                begin
                    if (count_reg[i] != COUNT_MAX)
                    begin
                        count_next[i] = count_reg[i] + COUNT_W'(1);
                    end
                end
                else if (!any_match && greater[i])
                begin
                    if (greater_prev[i])
                    begin
                        value_next[i] = value_prev[i];
                        count_next[i] = count_prev[i];
                    end
                    else
                    begin
                        value_next[i] = sample_value;
                        count_next[i] = COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                value_reg[i] <= '0;
                count_reg[i] <= '0;
            end
            strobe_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                value_reg[i] <= value_next[i];
                count_reg[i] <= count_next[i];
            end
            strobe_reg <= cmd.dump_en;
        end
    end

    assign head_valid = (count_reg[0] != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.dump_en)
        begin
            result_reg.entry_index <= cmd.dump_index;
            result_reg.entry_valid <= head_valid;
            result_reg.entry_value <= head_valid ? value_reg[0] : '0;
            result_reg.entry_count <= count_reg[0];
            result_reg.last        <= cmd.dump_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_strobe_follows_dump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_en |=> result_strobe)
        else $error("dump step produced no transfer");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> (result.entry_index == INDEX_W'(ENTRIES - 1)))
        else $error("last marker on wrong slot");

    a_head_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !cmd.dump_en) |=> head_valid)
        else $error("smallest slot emptied by a record");

endmodule

/* hw/rtl/smallest_values_count_table.sv */
// top level: table of the smallest distinct sample values with counts
// a record request is taken only while busy is low; one may be accepted every cycle while not busy
// a dump holds busy while it steps through the rotating slot table, one slot per cycle
// dump results are registered and appear in the cycle after each step, ENTRIES transfers, last on the final slot
// the receiver cannot stall: each result strobe lasts one cycle
// reset (rst_n low, asynchronous) empties every slot and ends any dump in progress
module smallest_values_count_table #(
    parameter int ENTRIES = svct_pkg::ENTRIES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  svct_pkg::in_item_t  request,
    output logic                result_strobe,
    output svct_pkg::out_item_t result
);
    import svct_pkg::*;

    cmd_t cmd;

    svct_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .busy   (busy),
        .cmd    (cmd)
    );

    svct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_value  (request.sample_value),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
